>>> src/rpbt_pkg.sv
// ----------------------------------------------------------------------------
// rpbt_pkg: shared types and constants of the prefix/branch slot tables
// Item types, command and status codes, controller interface structs and the
// lowest-set-bit helper used by the free-slot scan.
// ----------------------------------------------------------------------------
package rpbt_pkg;

   localparam int PREFIX_SLOTS_DEF = 64;
   localparam int BRANCH_SLOTS_DEF = 256;
   localparam int REF_BITS_DEF     = 16;
   localparam int MAP_WORD         = 64;

   localparam logic [2:0] CMD_REG_PREFIX   = 3'd0;
   localparam logic [2:0] CMD_ACQUIRE      = 3'd1;
   localparam logic [2:0] CMD_RELEASE      = 3'd2;
   localparam logic [2:0] CMD_READ_PREFIX  = 3'd3;
   localparam logic [2:0] CMD_ALLOC_BRANCH = 3'd4;
   localparam logic [2:0] CMD_FREE_BRANCH  = 3'd5;
   localparam logic [2:0] CMD_READ_BRANCH  = 3'd6;
   localparam logic [2:0] CMD_OFFSET       = 3'd7;

   localparam logic [2:0] STAT_OK    = 3'd0;
   localparam logic [2:0] STAT_FULL  = 3'd1;
   localparam logic [2:0] STAT_RANGE = 3'd2;
   localparam logic [2:0] STAT_ZERO  = 3'd3;
   localparam logic [2:0] STAT_SAT   = 3'd4;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [15:0]        prefix_sel;
      logic [15:0]        branch_sel;
      logic [15:0]        owner_in;
      logic signed [47:0] prefix_offset_in;
      logic [19:0]        prefix_tokens_in;
      logic [15:0]        prefix_blocks_in;
      logic signed [47:0] delta_offset_in;
      logic [19:0]        delta_tokens_in;
      logic [15:0]        delta_blocks_in;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [7:0]         assigned_id;
      logic [15:0]        ref_count;
      logic signed [47:0] offset_out;
      logic [19:0]        length_out;
      logic [15:0]        blocks_out;
      logic [15:0]        owner_out;
      logic [15:0]        parent_out;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_PF_ALLOC,
      ST_BR_ALLOC,
      ST_PF_RD,
      ST_PF_USE,
      ST_BR_RD,
      ST_BR_USE,
      ST_DONE
   } fsm_state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic decode;
      logic scan_clr;
      logic scan_step;
      logic pf_alloc;
      logic br_alloc;
      logic pf_rd;
      logic pf_use;
      logic br_rd;
      logic br_use;
      logic rsp_load;
   } dp_ctrl_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       psel_ok;
      logic       bsel_ok;
      logic       parent_ok;
      logic       scan_found;
      logic       scan_last;
      logic       clear_last;
   } dp_stat_type;

   function automatic logic [5:0] lowest_set(input logic [63:0] w);
      logic [5:0] r;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         if (w[i]) begin
            r = 6'(i);
         end
      end
      return r;
   endfunction

endpackage

>>> src/rpbt_ctrl.sv
// ----------------------------------------------------------------------------
// rpbt_ctrl: command sequencer
// Steps each item through decode, bitmap scan, table reads and updates, and
// owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module rpbt_ctrl
   import rpbt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_ctrl_type ctrl
);

   fsm_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            ctrl.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            ctrl.decode   = 1'b1;
            ctrl.scan_clr = 1'b1;
            case (stat.cmd)
               CMD_REG_PREFIX, CMD_ALLOC_BRANCH: state_in = ST_SCAN;
               CMD_ACQUIRE, CMD_RELEASE, CMD_READ_PREFIX:
                  state_in = stat.psel_ok ? ST_PF_RD : ST_DONE;
               default: state_in = stat.bsel_ok ? ST_BR_RD : ST_DONE;
            endcase
         end
         ST_SCAN: begin
            ctrl.scan_step = 1'b1;
            if (stat.scan_found) begin
               state_in = (stat.cmd == CMD_REG_PREFIX) ? ST_PF_ALLOC : ST_BR_ALLOC;
            end else if (stat.scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_PF_ALLOC: begin
            ctrl.pf_alloc = 1'b1;
            state_in      = ST_DONE;
         end
         ST_BR_ALLOC: begin
            ctrl.br_alloc = 1'b1;
            state_in      = stat.psel_ok ? ST_PF_RD : ST_DONE;
         end
         ST_PF_RD: begin
            ctrl.pf_rd = 1'b1;
            state_in   = ST_PF_USE;
         end
         ST_PF_USE: begin
            ctrl.pf_use = 1'b1;
            state_in    = ST_DONE;
         end
         ST_BR_RD: begin
            ctrl.br_rd = 1'b1;
            state_in   = ST_BR_USE;
         end
         ST_BR_USE: begin
            ctrl.br_use = 1'b1;
            if ((stat.cmd == CMD_FREE_BRANCH || stat.cmd == CMD_OFFSET) && stat.parent_ok) begin
               state_in = ST_PF_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.rsp_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> src/rpbt_datapath.sv
// ----------------------------------------------------------------------------
// rpbt_datapath: slot tables, free bitmaps and result assembly
// Holds the prefix and branch tables, scans the free bitmaps one word per
// cycle and performs the reference count read-modify-write.
// ----------------------------------------------------------------------------
module rpbt_datapath
   import rpbt_pkg::*;
#(
   parameter int PREFIX_SLOTS = PREFIX_SLOTS_DEF,
   parameter int BRANCH_SLOTS = BRANCH_SLOTS_DEF,
   parameter int REF_BITS     = REF_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  dp_ctrl_type ctrl,
   output dp_stat_type stat,
   output rsp_type     rsp_data
);

   localparam int PW    = (PREFIX_SLOTS + MAP_WORD - 1) / MAP_WORD;
   localparam int BW    = (BRANCH_SLOTS + MAP_WORD - 1) / MAP_WORD;
   localparam int PWB   = (PW > 1) ? $clog2(PW) : 1;
   localparam int BWB   = (BW > 1) ? $clog2(BW) : 1;
   localparam int SW    = (PWB > BWB) ? PWB : BWB;
   localparam int PIDX  = (PREFIX_SLOTS > 1) ? $clog2(PREFIX_SLOTS) : 1;
   localparam int BIDX  = (BRANCH_SLOTS > 1) ? $clog2(BRANCH_SLOTS) : 1;
   localparam int SLW   = (PIDX > BIDX) ? PIDX : BIDX;
   localparam int CLR_N = (PREFIX_SLOTS > BRANCH_SLOTS) ? PREFIX_SLOTS : BRANCH_SLOTS;
   localparam int CLRW  = (CLR_N > 1) ? $clog2(CLR_N) : 1;
   localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

   req_type rq_ff;
   rsp_type res_ff, out_ff;

   logic [PREFIX_SLOTS-1:0] pmap_ff;
   logic [BRANCH_SLOTS-1:0] bmap_ff;
   logic [SW-1:0]           sidx_ff;
   logic [SLW-1:0]          slot_ff;
   logic [CLRW-1:0]         clr_ff;

   // Prefix table
   logic [REF_BITS-1:0] pf_ref_ff [PREFIX_SLOTS];
   logic [47:0]         pf_off_ff [PREFIX_SLOTS];
   logic [19:0]         pf_len_ff [PREFIX_SLOTS];
   logic [15:0]         pf_blk_ff [PREFIX_SLOTS];
   logic [REF_BITS-1:0] pf_ref_q_ff;
   logic [47:0]         pf_off_q_ff;
   logic [19:0]         pf_len_q_ff;
   logic [15:0]         pf_blk_q_ff;

   // Branch table
   logic [15:0] br_own_ff [BRANCH_SLOTS];
   logic [15:0] br_par_ff [BRANCH_SLOTS];
   logic [47:0] br_off_ff [BRANCH_SLOTS];
   logic [19:0] br_len_ff [BRANCH_SLOTS];
   logic [15:0] br_blk_ff [BRANCH_SLOTS];
   logic [15:0] br_own_q_ff, br_par_q_ff, br_blk_q_ff;
   logic [47:0] br_off_q_ff;
   logic [19:0] br_len_q_ff;

   logic [PW*MAP_WORD-1:0] pmap_pad;
   logic [BW*MAP_WORD-1:0] bmap_pad;
   logic [63:0]            word;
   logic [5:0]             low_bit;
   logic                   is_pfx_scan, use_parent;
   logic                   pf_clr, br_clr;

   logic [REF_BITS-1:0] ref_cur, ref_new;
   logic [47:0]         off_cur;
   logic [15:0]         par_cur, pid;
   logic [PIDX-1:0]     pidx, pwr_idx;
   logic [BIDX-1:0]     bidx, bslot, bclr_idx;
   logic                pf_err_zero, pf_err_sat, is_acq, is_rel, upd_ok, rel_zero;
   logic                pf_ref_we, pf_ol_we, pf_blk_we;
   logic [REF_BITS-1:0] pf_ref_wd;
   logic [47:0]         pf_off_wd;
   logic [19:0]         pf_len_wd;
   logic [15:0]         pf_blk_wd;

   assign pmap_pad    = (PW*MAP_WORD)'(pmap_ff);
   assign bmap_pad    = (BW*MAP_WORD)'(bmap_ff);
   assign is_pfx_scan = (rq_ff.cmd == CMD_REG_PREFIX);
   assign word        = is_pfx_scan ? pmap_pad[PWB'(sidx_ff)*MAP_WORD +: MAP_WORD]
                                    : bmap_pad[BWB'(sidx_ff)*MAP_WORD +: MAP_WORD];
   assign low_bit     = lowest_set(word);

   // After reset every entry of both tables is written with zeros, one
   // entry of each table per cycle.
   assign pf_clr   = {1'b0, clr_ff} < (CLRW+1)'(PREFIX_SLOTS);
   assign br_clr   = {1'b0, clr_ff} < (CLRW+1)'(BRANCH_SLOTS);
   assign bclr_idx = BIDX'(clr_ff);

   assign par_cur    = br_par_q_ff;
   assign use_parent = (rq_ff.cmd == CMD_FREE_BRANCH) || (rq_ff.cmd == CMD_OFFSET);
   assign pid        = use_parent ? par_cur : rq_ff.prefix_sel;
   assign pidx       = PIDX'(pid);
   assign bidx       = BIDX'(rq_ff.branch_sel);
   assign bslot      = BIDX'(slot_ff);

   assign stat.cmd        = rq_ff.cmd;
   assign stat.psel_ok    = {1'b0, rq_ff.prefix_sel} < 17'(PREFIX_SLOTS);
   assign stat.bsel_ok    = {1'b0, rq_ff.branch_sel} < 17'(BRANCH_SLOTS);
   assign stat.parent_ok  = {1'b0, par_cur} < 17'(PREFIX_SLOTS);
   assign stat.scan_found = |word;
   assign stat.scan_last  = is_pfx_scan ? (sidx_ff == SW'(PW - 1)) : (sidx_ff == SW'(BW - 1));
   assign stat.clear_last = (clr_ff == CLRW'(CLR_N - 1));

   // Reference count update for acquire, release and their branch forms.
   assign ref_cur     = pf_ref_q_ff;
   assign off_cur     = pf_off_q_ff;
   assign is_acq      = (rq_ff.cmd == CMD_ACQUIRE) || (rq_ff.cmd == CMD_ALLOC_BRANCH);
   assign is_rel      = (rq_ff.cmd == CMD_RELEASE) || (rq_ff.cmd == CMD_FREE_BRANCH);
   assign pf_err_zero = (ref_cur == '0);
   assign pf_err_sat  = (ref_cur == REF_MAX);
   assign upd_ok      = is_acq ? !(pf_err_zero || pf_err_sat) : (is_rel && !pf_err_zero);
   assign ref_new     = is_acq ? ref_cur + 1'b1 : ref_cur - 1'b1;
   assign rel_zero    = is_rel && upd_ok && (ref_new == '0);

   always_comb begin
      pf_ref_we = 1'b0;
      pf_ol_we  = 1'b0;
      pf_blk_we = 1'b0;
      pwr_idx   = pidx;
      pf_ref_wd = ref_new;
      pf_off_wd = '1;
      pf_len_wd = '0;
      pf_blk_wd = rq_ff.prefix_blocks_in;
      if (ctrl.clear) begin
         pf_ref_we = pf_clr;
         pf_ol_we  = pf_clr;
         pf_blk_we = pf_clr;
         pwr_idx   = PIDX'(clr_ff);
         pf_ref_wd = '0;
         pf_off_wd = '0;
         pf_blk_wd = '0;
      end else if (ctrl.pf_alloc) begin
         pf_ref_we = 1'b1;
         pf_ol_we  = 1'b1;
         pf_blk_we = 1'b1;
         pwr_idx   = PIDX'(slot_ff);
         pf_ref_wd = REF_BITS'(1);
         pf_off_wd = rq_ff.prefix_offset_in;
         pf_len_wd = rq_ff.prefix_tokens_in;
      end else if (ctrl.pf_use && upd_ok) begin
         pf_ref_we = 1'b1;
         pf_ol_we  = rel_zero;
      end
   end

   // Prefix table storage
   always_ff @(posedge clock) begin
      if (pf_ref_we) begin
         pf_ref_ff[pwr_idx] <= pf_ref_wd;
      end
      if (pf_ol_we) begin
         pf_off_ff[pwr_idx] <= pf_off_wd;
         pf_len_ff[pwr_idx] <= pf_len_wd;
      end
      if (pf_blk_we) begin
         pf_blk_ff[pwr_idx] <= pf_blk_wd;
      end
      if (ctrl.pf_rd) begin
         pf_ref_q_ff <= pf_ref_ff[pidx];
         pf_off_q_ff <= pf_off_ff[pidx];
         pf_len_q_ff <= pf_len_ff[pidx];
         pf_blk_q_ff <= pf_blk_ff[pidx];
      end
   end

   // Branch table storage
   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         if (br_clr) begin
            br_own_ff[bclr_idx] <= '0;
            br_par_ff[bclr_idx] <= '0;
            br_off_ff[bclr_idx] <= '0;
            br_len_ff[bclr_idx] <= '0;
            br_blk_ff[bclr_idx] <= '0;
         end
      end else if (ctrl.br_alloc) begin
         br_own_ff[bslot] <= rq_ff.owner_in;
         br_par_ff[bslot] <= rq_ff.prefix_sel;
         br_off_ff[bslot] <= rq_ff.delta_offset_in;
         br_len_ff[bslot] <= rq_ff.delta_tokens_in;
         br_blk_ff[bslot] <= rq_ff.delta_blocks_in;
      end else if (ctrl.br_use && rq_ff.cmd == CMD_FREE_BRANCH) begin
         br_own_ff[bidx] <= 16'hFFFF;
      end
      if (ctrl.br_rd) begin
         br_own_q_ff <= br_own_ff[bidx];
         br_par_q_ff <= br_par_ff[bidx];
         br_off_q_ff <= br_off_ff[bidx];
         br_len_q_ff <= br_len_ff[bidx];
         br_blk_q_ff <= br_blk_ff[bidx];
      end
   end

   // Free bitmaps, clearing counter, scan counter and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pmap_ff <= '1;
         bmap_ff <= '1;
         sidx_ff <= '0;
         clr_ff  <= '0;
      end else begin
         if (ctrl.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (ctrl.pf_alloc) begin
            pmap_ff[PIDX'(slot_ff)] <= 1'b0;
         end else if (ctrl.pf_use && rel_zero) begin
            pmap_ff[pidx] <= 1'b1;
         end
         if (ctrl.br_alloc) begin
            bmap_ff[bslot] <= 1'b0;
         end else if (ctrl.br_use && rq_ff.cmd == CMD_FREE_BRANCH) begin
            bmap_ff[bidx] <= 1'b1;
         end
         if (ctrl.scan_clr) begin
            sidx_ff <= '0;
         end else if (ctrl.scan_step) begin
            sidx_ff <= sidx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.scan_step) begin
         slot_ff <= SLW'({sidx_ff, low_bit});
      end
   end

   // Request latch and result assembly
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         rq_ff  <= req_data;
         res_ff <= '0;
      end
      if (ctrl.decode) begin
         case (rq_ff.cmd)
            CMD_ACQUIRE, CMD_RELEASE, CMD_READ_PREFIX: begin
               if (!stat.psel_ok) begin
                  res_ff.status <= STAT_RANGE;
               end
            end
            CMD_FREE_BRANCH, CMD_READ_BRANCH: begin
               if (!stat.bsel_ok) begin
                  res_ff.status <= STAT_RANGE;
               end
            end
            CMD_OFFSET: begin
               if (!stat.bsel_ok) begin
                  res_ff.status     <= STAT_RANGE;
                  res_ff.offset_out <= '1;
               end
            end
            default: ;
         endcase
      end
      if (ctrl.scan_step && !stat.scan_found && stat.scan_last) begin
         res_ff.status <= STAT_FULL;
      end
      if (ctrl.pf_alloc) begin
         res_ff.assigned_id <= 8'(slot_ff);
         res_ff.ref_count   <= 16'd1;
      end
      if (ctrl.br_alloc) begin
         res_ff.assigned_id <= 8'(slot_ff);
      end
      if (ctrl.pf_use) begin
         case (rq_ff.cmd)
            CMD_ACQUIRE, CMD_RELEASE: begin
               if (upd_ok) begin
                  res_ff.ref_count <= 16'(ref_new);
               end else if (pf_err_zero) begin
                  res_ff.status <= STAT_ZERO;
               end else begin
                  res_ff.status <= STAT_SAT;
               end
            end
            CMD_ALLOC_BRANCH, CMD_FREE_BRANCH: begin
               res_ff.ref_count <= upd_ok ? 16'(ref_new) : 16'(ref_cur);
            end
            CMD_READ_PREFIX: begin
               res_ff.ref_count  <= 16'(ref_cur);
               res_ff.offset_out <= off_cur;
               res_ff.length_out <= pf_len_q_ff;
               res_ff.blocks_out <= pf_blk_q_ff;
            end
            CMD_OFFSET: res_ff.offset_out <= off_cur;
            default: ;
         endcase
      end
      if (ctrl.br_use) begin
         case (rq_ff.cmd)
            CMD_READ_BRANCH: begin
               res_ff.offset_out <= br_off_q_ff;
               res_ff.length_out <= br_len_q_ff;
               res_ff.blocks_out <= br_blk_q_ff;
               res_ff.owner_out  <= br_own_q_ff;
               res_ff.parent_out <= par_cur;
            end
            CMD_OFFSET: begin
               if (!stat.parent_ok) begin
                  res_ff.offset_out <= br_off_q_ff;
               end
            end
            default: ;
         endcase
      end
      if (ctrl.rsp_load) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_data = out_ff;

endmodule

>>> src/refcounted_prefix_branch_table_top.sv
// ----------------------------------------------------------------------------
// refcounted_prefix_branch_table_top: reference-counted prefix/branch tables
// Two slot tables with lowest-free-slot allocation from free bitmaps and
// saturating reference counts on prefixes, shared by one command engine.
//
//   Channel  Direction  Handshake             Payload
//   req_     in         req_valid/req_ready   req_type (command and fields)
//   rsp_     out        rsp_valid/rsp_ready   rsp_type (status and results)
//
// Items are handled one at a time. Acquire, release and both reads fetch
// the selected entry and then use it; free branch and the offset query
// fetch the branch and then its stored parent prefix, unless that parent
// is out of range. Register prefix scans the free bitmap one 64-bit word
// at a time, alloc branch scans, writes the branch and then updates its
// parent unless that is out of range; a full table ends after the whole
// scan, an id out of range right after decode. Reset is synchronous; after
// it the engine writes zeros through both tables, one entry of each per
// cycle, up to the slot count of the larger table (256 by default), before it
// takes an item. A finished result waits in the output register while the
// next item is accepted; the engine only stalls at the end of that next item.
// ----------------------------------------------------------------------------
module refcounted_prefix_branch_table_top
   import rpbt_pkg::*;
#(
   parameter int PREFIX_SLOTS = PREFIX_SLOTS_DEF,
   parameter int BRANCH_SLOTS = BRANCH_SLOTS_DEF,
   parameter int REF_BITS     = REF_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dp_ctrl_type ctrl;
   dp_stat_type stat;

   // The sequencer drives the strobes of each step; the datapath reports the
   // command, range checks, scan outcome and clearing progress back to it.
   rpbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   rpbt_datapath #(
      .PREFIX_SLOTS (PREFIX_SLOTS),
      .BRANCH_SLOTS (BRANCH_SLOTS),
      .REF_BITS     (REF_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctrl     (ctrl),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

>>> src/rpbt_checker.sv
// ----------------------------------------------------------------------------
// rpbt_checker: port-level checks of the slot table engine
// Watches the handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
module rpbt_checker
   import rpbt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result item changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("engine took a second item while busy");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STAT_FULL |->
         rsp_data.assigned_id == 8'd0 && rsp_data.ref_count == 16'd0)
      else $error("full status carries result fields");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STAT_OK |->
         rsp_data.owner_out == 16'd0 && rsp_data.parent_out == 16'd0 &&
         rsp_data.length_out == 20'd0 && rsp_data.blocks_out == 16'd0)
      else $error("error status carries read fields");

endmodule

bind refcounted_prefix_branch_table_top rpbt_checker u_rpbt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> verif/rpbt_table_checker.sv
// ----------------------------------------------------------------------------
// rpbt_table_checker: result checker for the prefix/branch slot tables
// Watches both channels and keeps its own copy of the two slot tables. It
// works out the result of every accepted command and compares each returned
// item, field by field, with the oldest result still awaited.
// ----------------------------------------------------------------------------
module rpbt_table_checker
   import rpbt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      awaited_count
);

   localparam int NPFX = PREFIX_SLOTS_DEF;
   localparam int NBR  = BRANCH_SLOTS_DEF;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   logic [NPFX-1:0] pfx_free;
   logic [15:0]     pfx_refs [NPFX];
   logic [47:0]     pfx_offs [NPFX];
   logic [19:0]     pfx_lens [NPFX];
   logic [15:0]     pfx_blks [NPFX];
   logic [NBR-1:0]  br_free;
   logic [15:0]     br_owner [NBR];
   logic [15:0]     br_parent [NBR];
   logic [47:0]     br_offs [NBR];
   logic [19:0]     br_lens [NBR];
   logic [15:0]     br_blks [NBR];

   rsp_type awaited_results [$];

   initial fail_count = 0;
   assign awaited_count = awaited_results.size();

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      fail_count++;
      $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
   endtask

   task automatic take_ref(input logic [15:0] id, output logic [2:0] st);
      if (id >= NPFX) begin
         st = STAT_RANGE;
      end else if (pfx_refs[id] == 0) begin
         st = STAT_ZERO;
      end else if (pfx_refs[id] == COUNT_MAX) begin
         st = STAT_SAT;
      end else begin
         pfx_refs[id]++;
         st = STAT_OK;
      end
   endtask

   task automatic drop_ref(input logic [15:0] id, output logic [2:0] st);
      if (id >= NPFX) begin
         st = STAT_RANGE;
      end else if (pfx_refs[id] == 0) begin
         st = STAT_ZERO;
      end else begin
         pfx_refs[id]--;
         if (pfx_refs[id] == 0) begin
            pfx_offs[id] = '1;
            pfx_lens[id] = '0;
            pfx_free[id] = 1'b1;
         end
         st = STAT_OK;
      end
   endtask

   function automatic logic [15:0] count_of(input logic [15:0] id);
      return (id < NPFX) ? pfx_refs[id] : 16'd0;
   endfunction

   task automatic predict_table_op(input req_type q, output rsp_type r);
      logic [2:0]  st;
      int          slot;
      logic [15:0] par;
      r = '0;
      slot = -1;
      st = STAT_OK;
      case (q.cmd)
         CMD_REG_PREFIX: begin
            for (int i = NPFX - 1; i >= 0; i--) if (pfx_free[i]) slot = i;
            if (slot < 0) begin
               st = STAT_FULL;
            end else begin
               pfx_free[slot] = 1'b0;
               pfx_refs[slot] = 16'd1;
               pfx_offs[slot] = q.prefix_offset_in;
               pfx_lens[slot] = q.prefix_tokens_in;
               pfx_blks[slot] = q.prefix_blocks_in;
               r.assigned_id = 8'(slot);
               r.ref_count = 16'd1;
            end
         end
         CMD_ACQUIRE, CMD_RELEASE: begin
            if (q.cmd == CMD_ACQUIRE) take_ref(q.prefix_sel, st);
            else drop_ref(q.prefix_sel, st);
            if (st == STAT_OK) r.ref_count = pfx_refs[q.prefix_sel];
         end
         CMD_READ_PREFIX: begin
            if (q.prefix_sel >= NPFX) begin
               st = STAT_RANGE;
            end else begin
               r.ref_count = pfx_refs[q.prefix_sel];
               r.offset_out = pfx_offs[q.prefix_sel];
               r.length_out = pfx_lens[q.prefix_sel];
               r.blocks_out = pfx_blks[q.prefix_sel];
            end
         end
         CMD_ALLOC_BRANCH: begin
            for (int i = NBR - 1; i >= 0; i--) if (br_free[i]) slot = i;
            if (slot < 0) begin
               st = STAT_FULL;
            end else begin
               br_free[slot] = 1'b0;
               br_owner[slot] = q.owner_in;
               br_parent[slot] = q.prefix_sel;
               br_offs[slot] = q.delta_offset_in;
               br_lens[slot] = q.delta_tokens_in;
               br_blks[slot] = q.delta_blocks_in;
               // A failed acquire of the parent does not fail the allocation.
               take_ref(q.prefix_sel, st);
               st = STAT_OK;
               r.assigned_id = 8'(slot);
               r.ref_count = count_of(q.prefix_sel);
            end
         end
         CMD_FREE_BRANCH: begin
            if (q.branch_sel >= NBR) begin
               st = STAT_RANGE;
            end else begin
               par = br_parent[q.branch_sel];
               drop_ref(par, st);
               st = STAT_OK;
               br_owner[q.branch_sel] = 16'hFFFF;
               br_free[q.branch_sel] = 1'b1;
               r.ref_count = count_of(par);
            end
         end
         CMD_READ_BRANCH: begin
            if (q.branch_sel >= NBR) begin
               st = STAT_RANGE;
            end else begin
               r.offset_out = br_offs[q.branch_sel];
               r.length_out = br_lens[q.branch_sel];
               r.blocks_out = br_blks[q.branch_sel];
               r.owner_out = br_owner[q.branch_sel];
               r.parent_out = br_parent[q.branch_sel];
            end
         end
         default: begin
            if (q.branch_sel >= NBR) begin
               st = STAT_RANGE;
               r.offset_out = '1;
            end else begin
               par = br_parent[q.branch_sel];
               r.offset_out = (par < NPFX) ? pfx_offs[par] : br_offs[q.branch_sel];
            end
         end
      endcase
      r.status = st;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         pfx_free = '1;
         br_free = '1;
         for (int i = 0; i < NPFX; i++) begin
            pfx_refs[i] = '0; pfx_offs[i] = '0; pfx_lens[i] = '0; pfx_blks[i] = '0;
         end
         for (int i = 0; i < NBR; i++) begin
            br_owner[i] = '0; br_parent[i] = '0; br_offs[i] = '0;
            br_lens[i] = '0; br_blks[i] = '0;
         end
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected result item", 64'(got), 64'd0);
            end else begin
               want = awaited_results.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", 64'(got.status), 64'(want.status));
               if (got.assigned_id != want.assigned_id)
                  report_mismatch("assigned_id", 64'(got.assigned_id),
                                  64'(want.assigned_id));
               if (got.ref_count != want.ref_count)
                  report_mismatch("ref_count", 64'(got.ref_count), 64'(want.ref_count));
               if (got.offset_out != want.offset_out)
                  report_mismatch("offset_out", 64'(unsigned'(got.offset_out)),
                                  64'(unsigned'(want.offset_out)));
               if (got.length_out != want.length_out)
                  report_mismatch("length_out", 64'(got.length_out),
                                  64'(want.length_out));
               if (got.blocks_out != want.blocks_out)
                  report_mismatch("blocks_out", 64'(got.blocks_out),
                                  64'(want.blocks_out));
               if (got.owner_out != want.owner_out)
                  report_mismatch("owner_out", 64'(got.owner_out), 64'(want.owner_out));
               if (got.parent_out != want.parent_out)
                  report_mismatch("parent_out", 64'(got.parent_out),
                                  64'(want.parent_out));
            end
         end
         if (req_valid && req_ready) begin
            predict_table_op(req_data, want);
            awaited_results.push_back(want);
         end
      end
   end

endmodule

>>> verif/tb_refcounted_prefix_branch_table_top.sv
// ----------------------------------------------------------------------------
// tb_refcounted_prefix_branch_table_top: testbench of the prefix/branch tables
// Drives a short directed run of commands and then random command mixes under
// varying sender and receiver idling, while a separate checker predicts and
// compares every result item.
// ----------------------------------------------------------------------------
module tb_refcounted_prefix_branch_table_top;
   import rpbt_pkg::*;

   localparam int RANDOM_PER_PHASE = 286;
   localparam int STALL_LIMIT      = 5000;
   localparam int HOLD_CYCLES      = 300;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int      fail_count;
   int      awaited_count;
   logic    req_fire;
   int      idle_run;
   int      items_sent;

   // Percentages of idling on either side, altered by the stimulus phases.
   int      send_idle_pct;
   int      recv_stall_pct;
   logic    hold_request;
   int      hold_left;

   refcounted_prefix_branch_table_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   rpbt_table_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .awaited_count (awaited_count)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The input handshake is sampled at the rising edge, before the block's
   // own registers update, and read back by the sender at the next falling
   // edge.
   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
   end

   // The watchdog counts cycles in which neither channel moves an item. The
   // long receiver hold-off stays well under its limit.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_run <= 0;
      end else begin
         idle_run <= idle_run + 1;
         if (idle_run >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("refcounted_prefix_branch_table_top verification failed");
            $finish;
         end
      end
   end

   // The receiver. A hold-off request makes it refuse results until its hold-off
   // counter runs down, so that the block fills up and stops taking items;
   // otherwise it stalls at random at the current rate. Each falling edge
   // carries exactly one assignment to rsp_ready.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_request && hold_left == 0) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 1) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         hold_left <= 0;
      end
   end

   function automatic logic [47:0] pick_offset();
      case ($urandom_range(9))
         0: return '1;
         1: return 48'h7FFF_FFFF_FFFF;
         2: return '0;
         default: return 48'({$urandom, $urandom});
      endcase
   endfunction

   function automatic logic [15:0] pick_prefix_sel();
      int r;
      r = $urandom_range(99);
      if (r < 75) return 16'($urandom_range(15));
      if (r < 88) return 16'($urandom_range(PREFIX_SLOTS_DEF - 1));
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_branch_sel();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 16'($urandom_range(63));
      if (r < 87) return 16'($urandom_range(BRANCH_SLOTS_DEF - 1));
      return 16'($urandom);
   endfunction

   // Builds a random command. The mix selects the weighting: an even spread,
   // one that favours registering prefixes so that the prefix table fills,
   // or one that favours allocating branches so that the branch table fills.
   function automatic req_type random_table_op(input int mix);
      req_type q;
      int      r;
      q.prefix_sel = pick_prefix_sel();
      q.branch_sel = pick_branch_sel();
      q.owner_in = 16'($urandom);
      q.prefix_offset_in = pick_offset();
      q.prefix_tokens_in = 20'($urandom);
      q.prefix_blocks_in = 16'($urandom);
      q.delta_offset_in = pick_offset();
      q.delta_tokens_in = 20'($urandom);
      q.delta_blocks_in = 16'($urandom);
      r = $urandom_range(99);
      if (mix == 1 && r < 45) begin
         q.cmd = CMD_REG_PREFIX;
      end else if (mix == 2 && r < 70) begin
         q.cmd = CMD_ALLOC_BRANCH;
      end else if (mix == 2 && r < 75) begin
         q.cmd = CMD_FREE_BRANCH;
      end else begin
         q.cmd = 3'($urandom_range(7));
      end
      return q;
   endfunction

   // Offers one item at a falling edge and waits until it has been taken.
   // The sender may idle before it; valid never drops while an item waits.
   task automatic send_item(input req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      do begin
         @(negedge clock);
      end while (!req_fire);
      items_sent++;
   endtask

   task automatic directed_op(input logic [2:0] cmd, input logic [15:0] psel,
                              input logic [15:0] bsel, input logic [47:0] offs,
                              input logic [19:0] toks);
      req_type q;
      q = '0;
      q.cmd = cmd;
      q.prefix_sel = psel;
      q.branch_sel = bsel;
      q.owner_in = ~psel;
      q.prefix_offset_in = offs;
      q.prefix_tokens_in = toks;
      q.prefix_blocks_in = ~toks[15:0];
      q.delta_offset_in = ~offs;
      q.delta_tokens_in = ~toks;
      q.delta_blocks_in = toks[15:0];
      send_item(q);
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      items_sent = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request <= 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: field extremes, every command, release to zero and a
      // release of a freed prefix, reads out of range, a branch whose parent
      // is out of range, and a branch freed twice.
      directed_op(CMD_READ_PREFIX, 16'd0, 16'd0, '0, '0);
      directed_op(CMD_REG_PREFIX, 16'd0, 16'd0, '1, '1);
      directed_op(CMD_REG_PREFIX, 16'd0, 16'd0, 48'h7FFF_FFFF_FFFF, '0);
      directed_op(CMD_ACQUIRE, 16'd0, 16'd0, '0, '0);
      directed_op(CMD_RELEASE, 16'd0, 16'd0, '0, '0);
      directed_op(CMD_RELEASE, 16'd0, 16'd0, '0, '0);
      directed_op(CMD_RELEASE, 16'd0, 16'd0, '0, '0);
      directed_op(CMD_ACQUIRE, 16'd0, 16'd0, '0, '0);
      directed_op(CMD_READ_PREFIX, 16'd0, 16'd0, '0, '0);
      directed_op(CMD_READ_PREFIX, 16'd64, 16'd0, '0, '0);
      directed_op(CMD_ACQUIRE, 16'hFFFF, 16'd0, '0, '0);
      directed_op(CMD_RELEASE, 16'hFFFF, 16'd0, '0, '0);
      directed_op(CMD_ALLOC_BRANCH, 16'd1, 16'd0, 48'h1234_5678_9ABC, 20'h5A5A5);
      directed_op(CMD_ALLOC_BRANCH, 16'hFFFF, 16'd0, 48'h0000_FFFF_0000, 20'hA5A5A);
      directed_op(CMD_READ_BRANCH, 16'd0, 16'd0, '0, '0);
      directed_op(CMD_READ_BRANCH, 16'd0, 16'd1, '0, '0);
      directed_op(CMD_OFFSET, 16'd0, 16'd0, '0, '0);
      directed_op(CMD_OFFSET, 16'd0, 16'd1, '0, '0);
      directed_op(CMD_OFFSET, 16'd0, 16'hFFFF, '0, '0);
      directed_op(CMD_FREE_BRANCH, 16'd0, 16'd0, '0, '0);
      directed_op(CMD_FREE_BRANCH, 16'd0, 16'd0, '0, '0);
      directed_op(CMD_FREE_BRANCH, 16'd0, 16'd256, '0, '0);
      directed_op(CMD_READ_BRANCH, 16'd0, 16'd0, '0, '0);
      directed_op(CMD_READ_BRANCH, 16'd0, 16'hFFFF, '0, '0);

      // Random part in five phases, each with its own idling and mix.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            3: begin send_idle_pct = 19; recv_stall_pct = 19; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // The last phase opens with a long receiver hold-off while items
            // keep being offered.
            hold_request <= (phase == 4 && n == 0);
            send_item(random_table_op(phase == 1 ? 1 : (phase == 2 ? 2 : 0)));
         end
      end
      hold_request <= 1'b0;
      req_valid <= 1'b0;

      while (awaited_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("Covered %0d commands: directed corner cases, then random mixes", items_sent);
      $display("filling both tables under sender idling, receiver stalls and a long hold-off.");
      if (fail_count == 0 && awaited_count == 0) begin
         $display("refcounted_prefix_branch_table_top verification clean");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, awaited_count);
         $display("refcounted_prefix_branch_table_top verification failed");
      end
      $finish;
   end

endmodule
